[design/lrl_pkg.sv]
// Shared types, field widths and codes for the LRU replacement list.
package lrl_pkg;

    localparam int SLOTS_DEFAULT = 1024;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;

    // Reciprocal division of the 10-bit slot number by the slot count
    localparam int RCP_SHIFT = 20;
    localparam int RCP_W     = RCP_SHIFT;
    localparam int PROD_W    = SLOT_W + RCP_W;
    localparam int SLOTS_W   = 17;
    localparam int MUL_W     = SLOT_W + SLOTS_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVICT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_LISTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LISTED     = 2'd3;

    typedef struct packed {
        logic capture;
        logic wrap;
        logic look;
        logic decide;
        logic link;
        logic clear;
    } lrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic move;
    } lrl_stat_t;

endpackage

[design/lrl_ctrl.sv]
// Sequencer for the LRU replacement list: clearing sweep and per-item steps.
module lrl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output lrl_pkg::lrl_cmd_t cmd,
    input  lrl_pkg::lrl_stat_t stat
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WRAP   = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_LINK   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WRAP;
                end
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.move ? S_LINK : S_IDLE;
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/lrl_dp.sv]
// Datapath of the LRU replacement list: link memories, membership bits, head and tail.
module lrl_dp
#(
    parameter int SLOTS = lrl_pkg::SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrl_pkg::lrl_cmd_t             cmd,
    output lrl_pkg::lrl_stat_t            stat,
    input  logic [lrl_pkg::FUNC_W-1:0]    func,
    input  logic [lrl_pkg::SLOT_W-1:0]    slot,
    output logic                          done,
    output logic [lrl_pkg::STATUS_W-1:0]  status,
    output logic [lrl_pkg::SLOT_W-1:0]    victim
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RECIP = ((1 << lrl_pkg::RCP_SHIFT) + SLOTS - 1) / SLOTS;

    logic [IW-1:0] next_mem [SLOTS];
    logic [IW-1:0] prev_mem [SLOTS];
    logic          listed_mem [SLOTS];

    logic [lrl_pkg::FUNC_W-1:0] func_reg;
    logic [lrl_pkg::SLOT_W-1:0] slot_reg;
    logic [lrl_pkg::SLOT_W-1:0] quot_reg;
    logic [IW-1:0]              s_reg;
    logic [IW-1:0]              head_reg;
    logic [IW-1:0]              head_next;
    logic [IW-1:0]              tail_reg;
    logic [IW-1:0]              tail_next;
    logic                       empty_reg;
    logic                       empty_next;
    logic [IW-1:0]              clr_cnt_reg;

    logic          lst_rd;
    logic [IW-1:0] nxt_rd;
    logic [IW-1:0] prv_rd;
    logic [IW-1:0] rd_addr;

    logic          nx_we;
    logic [IW-1:0] nx_wa;
    logic [IW-1:0] nx_wd;
    logic          pv_we;
    logic [IW-1:0] pv_wa;
    logic [IW-1:0] pv_wd;
    logic          ls_we;
    logic [IW-1:0] ls_wa;
    logic          ls_wd;

    logic                          fin;
    logic [lrl_pkg::STATUS_W-1:0]  fin_status;
    logic [lrl_pkg::SLOT_W-1:0]    fin_victim;

    logic                          done_reg;
    logic [lrl_pkg::STATUS_W-1:0]  status_reg;
    logic [lrl_pkg::SLOT_W-1:0]    victim_reg;

    logic [lrl_pkg::PROD_W-1:0] quot_prod;
    logic [lrl_pkg::MUL_W-1:0]  rem_full;

    // Slot modulo SLOTS: exact quotient by reciprocal, then subtract
    assign quot_prod = lrl_pkg::PROD_W'(slot) * lrl_pkg::PROD_W'(RECIP);
    assign rem_full  = lrl_pkg::MUL_W'(slot_reg)
                     - lrl_pkg::MUL_W'(quot_reg) * lrl_pkg::MUL_W'(SLOTS);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            slot_reg <= slot;
            quot_reg <= quot_prod[lrl_pkg::PROD_W-1:lrl_pkg::RCP_SHIFT];
        end
        if (cmd.wrap)
        begin
            s_reg <= rem_full[IW-1:0];
        end
    end

    assign rd_addr = (func_reg == lrl_pkg::FUNC_EVICT) ? tail_reg : s_reg;

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (cmd.look)
        begin
            nxt_rd <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (cmd.look)
        begin
            prv_rd <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            listed_mem[ls_wa] <= ls_wd;
        end
        if (cmd.look)
        begin
            lst_rd <= listed_mem[rd_addr];
        end
    end

    assign stat.clr_last = (clr_cnt_reg == IW'(SLOTS - 1));
    assign stat.move     = (func_reg == lrl_pkg::FUNC_TOUCH) && lst_rd && (s_reg != head_reg);

    always_comb
    begin
        nx_we      = 1'b0;
        nx_wa      = s_reg;
        nx_wd      = head_reg;
        pv_we      = 1'b0;
        pv_wa      = head_reg;
        pv_wd      = s_reg;
        ls_we      = 1'b0;
        ls_wa      = s_reg;
        ls_wd      = 1'b0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        fin        = 1'b0;
        fin_status = lrl_pkg::ST_DONE;
        fin_victim = '0;

        if (cmd.clear)
        begin
            ls_we = 1'b1;
            ls_wa = clr_cnt_reg;
        end
        else if (cmd.link)
        begin
            // second half of a touch: put the slot in front of the head
            nx_we     = 1'b1;
            pv_we     = 1'b1;
            head_next = s_reg;
            fin       = 1'b1;
        end
        else if (cmd.decide)
        begin
            fin = !stat.move;
            case (func_reg)
                lrl_pkg::FUNC_INSERT:
                begin
                    if (lst_rd)
                    begin
                        fin_status = lrl_pkg::ST_LISTED;
                    end
                    else
                    begin
                        ls_we = 1'b1;
                        ls_wd = 1'b1;
                        head_next = s_reg;
                        if (empty_reg)
                        begin
                            tail_next  = s_reg;
                            empty_next = 1'b0;
                        end
                        else
                        begin
                            nx_we = 1'b1;
                            pv_we = 1'b1;
                        end
                    end
                end
                lrl_pkg::FUNC_TOUCH:
                begin
                    if (!lst_rd)
                    begin
                        fin_status = lrl_pkg::ST_NOT_LISTED;
                    end
                    else if (stat.move)
                    begin
                        // unlink: the slot is not the head here
                        if (s_reg == tail_reg)
                        begin
                            tail_next = prv_rd;
                        end
                        else
                        begin
                            nx_we = 1'b1;
                            nx_wa = prv_rd;
                            nx_wd = nxt_rd;
                            pv_we = 1'b1;
                            pv_wa = nxt_rd;
                            pv_wd = prv_rd;
                        end
                    end
                end
                lrl_pkg::FUNC_EVICT:
                begin
                    if (empty_reg)
                    begin
                        fin_status = lrl_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fin_victim = lrl_pkg::SLOT_W'(tail_reg);
                        ls_we      = 1'b1;
                        ls_wa      = tail_reg;
                        if (tail_reg == head_reg)
                        begin
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            tail_next = prv_rd;
                        end
                    end
                end
                default:
                begin
                    fin_status = lrl_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            done_reg  <= fin;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            status_reg <= fin_status;
            victim_reg <= fin_victim;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign victim = victim_reg;

endmodule

[design/lru_replacement_list.sv]
// LRU replacement list top level: slot order held as a doubly linked list.
// Each item steps through capture, modulo wrap, registered link read (look), decide and,
// for a touch that moves a slot, link; the link writes fall in the decide and link steps.
// Busy is high through these steps, so no new item is taken until the last one is done.
// Reset: after rst_n rises, busy stays high for SLOTS cycles while the membership bits clear.
// The receiver cannot stall: done is high for one cycle with status and victim.
module lru_replacement_list
#(
    parameter int SLOTS = lrl_pkg::SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lrl_pkg::FUNC_W-1:0]    func,
    input  logic [lrl_pkg::SLOT_W-1:0]    slot,
    output logic                          done,
    output logic [lrl_pkg::STATUS_W-1:0]  status,
    output logic [lrl_pkg::SLOT_W-1:0]    victim
);

    lrl_pkg::lrl_cmd_t  cmd;
    lrl_pkg::lrl_stat_t stat;

    lrl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    lrl_dp
    #(
        .SLOTS (SLOTS)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .func   (func),
        .slot   (slot),
        .done   (done),
        .status (status),
        .victim (victim)
    );

endmodule

[verif/lru_replacement_list_checker.sv]
// Checker for the LRU replacement list: predicts each outcome and compares the results.
module lru_replacement_list_checker
    import lrl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [SLOT_W-1:0]   slot,
    input  logic                done,
    input  logic [STATUS_W-1:0] status,
    input  logic [SLOT_W-1:0]   victim,
    output int                  mismatches,
    output int                  outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   victim;
    } lru_outcome_t;

    // Shadow copy of the recency order
    logic [SLOT_W-1:0] toward_tail [SLOTS];
    logic [SLOT_W-1:0] toward_head [SLOTS];
    bit                on_list     [SLOTS];
    logic [SLOT_W-1:0] mru_slot;
    logic [SLOT_W-1:0] lru_slot;
    bit                order_empty;

    lru_outcome_t due_outcomes [$];
    lru_outcome_t want;

    function automatic void clear_order();
        for (int i = 0; i < SLOTS; i++)
        begin
            toward_tail[i] = '0;
            toward_head[i] = '0;
            on_list[i] = 1'b0;
        end
        mru_slot = '0;
        lru_slot = '0;
        order_empty = 1'b1;
    endfunction

    function automatic void unlink(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] n;
        p = toward_head[s];
        n = toward_tail[s];
        if (s == mru_slot && s == lru_slot)
            order_empty = 1'b1;
        else if (s == mru_slot)
            mru_slot = n;
        else if (s == lru_slot)
            lru_slot = p;
        else
        begin
            toward_tail[p] = n;
            toward_head[n] = p;
        end
        on_list[s] = 1'b0;
    endfunction

    function automatic void push_front(input logic [SLOT_W-1:0] s);
        if (order_empty)
        begin
            mru_slot = s;
            lru_slot = s;
            order_empty = 1'b0;
        end
        else
        begin
            toward_tail[s] = mru_slot;
            toward_head[mru_slot] = s;
            mru_slot = s;
        end
        on_list[s] = 1'b1;
    endfunction

    function automatic lru_outcome_t apply_request(input logic [FUNC_W-1:0] f,
                                                   input logic [SLOT_W-1:0] raw);
        lru_outcome_t o;
        logic [SLOT_W-1:0] s;
        s = SLOT_W'(raw % SLOTS);
        o.status = ST_DONE;
        o.victim = '0;
        case (f)
            FUNC_INSERT:
                if (on_list[s])
                    o.status = ST_LISTED;
                else
                    push_front(s);
            FUNC_TOUCH:
                if (!on_list[s])
                    o.status = ST_NOT_LISTED;
                else if (s != mru_slot)
                begin
                    unlink(s);
                    push_front(s);
                end
            FUNC_EVICT:
                if (order_empty)
                    o.status = ST_EMPTY;
                else
                begin
                    o.victim = lru_slot;
                    unlink(lru_slot);
                end
            default:
                ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_order();
            due_outcomes.delete();
            mismatches = 0;
        end
        else
        begin
            if (done)
            begin
                if (due_outcomes.size() == 0)
                begin
                    $display("%0t: result with none expected: status %0d victim %0d",
                             $time, status, victim);
                    mismatches++;
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        mismatches++;
                    end
                    if (victim !== want.victim)
                    begin
                        $display("%0t: victim expected %0d actual %0d",
                                 $time, want.victim, victim);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                due_outcomes.push_back(apply_request(func, slot));
        end
        outstanding = due_outcomes.size();
    end

endmodule

[verif/lru_replacement_list_tb.sv]
// Testbench top for the LRU replacement list: request stimulus and verdict.
module lru_replacement_list_tb;
    import lrl_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 50;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [FUNC_W-1:0]   func = FUNC_INSERT;
    logic [SLOT_W-1:0]   slot = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   victim;
    int                  mismatches;
    int                  outstanding;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lru_replacement_list i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .func   (func),
        .slot   (slot),
        .done   (done),
        .status (status),
        .victim (victim)
    );

    lru_replacement_list_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .slot        (slot),
        .done        (done),
        .status      (status),
        .victim      (victim),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Present a request and hold it until the block takes it
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s);
        start <= 1'b1;
        func <= f;
        slot <= s;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_after(input bit allow);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (allow && r >= 55)
            gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        logic [SLOT_W-1:0] base;
        logic [SLOT_W-1:0] s;
        logic [FUNC_W-1:0] f;
        int pool;
        int mode;
        int r;
        bit gaps_on;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, sole slot, extremes, head, tail and middle touches
        issue(FUNC_EVICT, 10'd0);
        issue(FUNC_TOUCH, 10'd5);
        issue(FUNC_NONE, 10'd1023);
        issue(FUNC_INSERT, 10'd0);
        issue(FUNC_TOUCH, 10'd0);
        issue(FUNC_INSERT, 10'd0);
        issue(FUNC_EVICT, 10'd1023);
        issue(FUNC_INSERT, 10'd1023);
        issue(FUNC_INSERT, 10'd0);
        issue(FUNC_INSERT, 10'd512);
        issue(FUNC_INSERT, 10'h155);
        issue(FUNC_INSERT, 10'h2aa);
        issue(FUNC_TOUCH, 10'd1023);
        issue(FUNC_TOUCH, 10'd512);
        issue(FUNC_TOUCH, 10'd512);
        issue(FUNC_TOUCH, 10'd7);
        issue(FUNC_INSERT, 10'h155);
        issue(FUNC_NONE, 10'd0);
        repeat (6) issue(FUNC_EVICT, 10'd0);
        issue(FUNC_TOUCH, 10'h2aa);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph % 3 == 1)
            begin
                start <= 1'b0;
                wait_drained();
            end
            case ($urandom_range(0, 3))
                0: pool = 4;
                1: pool = 16;
                2: pool = 64;
                default: pool = 1024;
            endcase
            base = SLOT_W'($urandom_range(0, 1023));
            mode = ph % 3;
            gaps_on = (ph % 4 != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                // grow, shrink or hold the list length
                if (r < ((mode == 0) ? 50 : (mode == 1) ? 20 : 35))
                    f = FUNC_INSERT;
                else if (r < ((mode == 0) ? 85 : (mode == 1) ? 50 : 70))
                    f = FUNC_TOUCH;
                else if (r < 97)
                    f = FUNC_EVICT;
                else
                    f = FUNC_NONE;
                s = base + SLOT_W'($urandom_range(0, pool - 1));
                issue(f, s);
                idle_after(gaps_on);
            end
        end
        start <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
design/lrl_pkg.sv
design/lrl_ctrl.sv
design/lrl_dp.sv
design/lru_replacement_list.sv
verif/lru_replacement_list_checker.sv
verif/lru_replacement_list_tb.sv
